FILE: sv/ses_pkg.sv
package ses_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_FIND = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_FIND = 1'b1
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

FILE: sv/searchable_element_stack_unit.sv
// Searchable element stack: a bounded LIFO of handles, each kept with a tag.
// Input channel (in_valid/in_ready) carries one operation per transfer:
// push, pop, peek or find. Output channel (out_valid/out_ready) returns
// exactly one result per operation, in order.
// Entries sit in a row of cells, top of stack in cell 0; push and pop shift
// the whole row by one place, and every cell compares its tag with the key.
// Timing: push, pop and peek results appear in the output register the cycle
// after the input transfer; a find first registers its match vector, which
// is then reduced to the nearest-to-top depth and registered as the result.
// Throughput: one push, pop or peek per cycle while the output is not stalled;
// a find holds off the input until its result has been registered.
// Faults (pop/peek on empty, push on full) leave the stack unchanged.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; stored handles and tags are not cleared.
// While the receiver stalls, the result is held and a new input transfer is
// taken only once the output register is free or being drained.
module searchable_element_stack_unit #(
  parameter int DEPTH       = ses_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = ses_pkg::HANDLE_BITS_DEF,
  parameter int TAG_BITS    = ses_pkg::TAG_BITS_DEF,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [HANDLE_BITS-1:0] in_node_handle,
  input  logic [TAG_BITS-1:0]    in_tag_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [CNT_W-1:0]       out_position,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic                   out_is_empty,
  output logic                   out_fault
);
  import ses_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [DEPTH-1:0]       hits_r, hits_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [HANDLE_BITS-1:0] out_handle_r, out_handle_nxt;
  logic [CNT_W-1:0]       out_position_r, out_position_nxt;
  logic [CNT_W-1:0]       out_entry_count_r, out_entry_count_nxt;
  logic                   out_is_empty_r, out_is_empty_nxt;
  logic                   out_fault_r, out_fault_nxt;

  shift_ctrl_t            ctrl;
  logic                   fire;
  logic                   out_free;
  logic                   is_full;
  logic                   is_zero;
  func_t                  func;
  logic [CNT_W-1:0]       found_pos;

  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  logic [TAG_BITS-1:0]    cell_tag    [DEPTH];
  logic [DEPTH-1:0]       cell_match;
  logic [DEPTH-1:0]       cell_hit;

  assign func     = func_t'(in_func);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign fire     = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_zero  = (count_r == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] above_handle;
    logic [TAG_BITS-1:0]    above_tag;
    logic [HANDLE_BITS-1:0] below_handle;
    logic [TAG_BITS-1:0]    below_tag;

    if (i == 0) begin : g_top
      assign above_handle = in_node_handle;
      assign above_tag    = in_tag_key;
    end else begin : g_mid
      assign above_handle = cell_handle[i-1];
      assign above_tag    = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below_handle = '0;
      assign below_tag    = '0;
    end else begin : g_up
      assign below_handle = cell_handle[i+1];
      assign below_tag    = cell_tag[i+1];
    end

    ses_cell #(
      .HANDLE_BITS (HANDLE_BITS),
      .TAG_BITS    (TAG_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .above_handle (above_handle),
      .above_tag    (above_tag),
      .below_handle (below_handle),
      .below_tag    (below_tag),
      .key          (in_tag_key),
      .handle       (cell_handle[i]),
      .tag          (cell_tag[i]),
      .match        (cell_match[i])
    );

    assign cell_hit[i] = cell_match[i] && (count_r > CNT_W'(i));
  end

  ses_first_match #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_first_match (
    .hits     (hits_r),
    .position (found_pos)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (fire && func == FUNC_FIND) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl                = '0;
    count_nxt           = count_r;
    hits_nxt            = hits_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_handle_nxt      = out_handle_r;
    out_position_nxt    = out_position_r;
    out_entry_count_nxt = out_entry_count_r;
    out_is_empty_nxt    = out_is_empty_r;
    out_fault_nxt       = out_fault_r;
    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          out_handle_nxt   = '0;
          out_position_nxt = '0;
          out_fault_nxt    = 1'b0;
          case (func)
            FUNC_PUSH: begin
              if (is_full) begin
                out_fault_nxt = 1'b1;
              end else begin
                ctrl.push = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (is_zero) begin
                out_fault_nxt = 1'b1;
              end else begin
                out_handle_nxt = cell_handle[0];
                if (func == FUNC_POP) begin
                  ctrl.pop  = 1'b1;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            default: begin
              hits_nxt = cell_hit;
            end
          endcase
          if (func != FUNC_FIND) begin
            out_valid_nxt       = 1'b1;
            out_entry_count_nxt = count_nxt;
            out_is_empty_nxt    = (count_nxt == '0);
          end
        end
      end
      ST_FIND: begin
        out_valid_nxt       = 1'b1;
        out_position_nxt    = found_pos;
        out_entry_count_nxt = count_r;
        out_is_empty_nxt    = is_zero;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hits_r            <= hits_nxt;
    out_handle_r      <= out_handle_nxt;
    out_position_r    <= out_position_nxt;
    out_entry_count_r <= out_entry_count_nxt;
    out_is_empty_r    <= out_is_empty_nxt;
    out_fault_r       <= out_fault_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_handle      = out_handle_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_fault       = out_fault_r;

endmodule

FILE: sv/ses_cell.sv
module ses_cell #(
  parameter int HANDLE_BITS = ses_pkg::HANDLE_BITS_DEF,
  parameter int TAG_BITS    = ses_pkg::TAG_BITS_DEF
) (
  input  logic                    clk,
  input  ses_pkg::shift_ctrl_t    ctrl,
  input  logic [HANDLE_BITS-1:0]  above_handle,
  input  logic [TAG_BITS-1:0]     above_tag,
  input  logic [HANDLE_BITS-1:0]  below_handle,
  input  logic [TAG_BITS-1:0]     below_tag,
  input  logic [TAG_BITS-1:0]     key,
  output logic [HANDLE_BITS-1:0]  handle,
  output logic [TAG_BITS-1:0]     tag,
  output logic                    match
);
  import ses_pkg::*;

  logic [HANDLE_BITS-1:0] handle_r;
  logic [TAG_BITS-1:0]    tag_r;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      handle_r <= above_handle;
      tag_r    <= above_tag;
    end else if (ctrl.pop) begin
      handle_r <= below_handle;
      tag_r    <= below_tag;
    end
  end

  assign handle = handle_r;
  assign tag    = tag_r;
  assign match  = (tag_r == key);

endmodule

FILE: sv/ses_first_match.sv
module ses_first_match #(
  parameter int DEPTH = ses_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic [DEPTH-1:0] hits,
  output logic [CNT_W-1:0] position
);
  import ses_pkg::*;

  logic [DEPTH-1:0] first;

  assign first = hits & (~hits + DEPTH'(1));

  always_comb begin
    position = '0;
    for (int i = 0; i < DEPTH; i++) begin
      position = position | (first[i] ? CNT_W'(i + 1) : CNT_W'(0));
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ses_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int HW = HANDLE_BITS_DEF;
  localparam int TW = TAG_BITS_DEF;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 325;

  typedef struct packed {
    logic [HW-1:0] handle;
    logic [CW-1:0] position;
    logic [CW-1:0] count;
    logic          empty;
    logic          fault;
  } stack_result_t;

  class stack_mirror;
    logic [HW-1:0] handles[STACK_DEPTH];
    logic [TW-1:0] tags[STACK_DEPTH];
    int fill;
    stack_result_t expected_results[$];
    int mismatches;
    int checked;
    int ops;
    int pushes;
    int finds_hit;
    int full_faults;
    int empty_faults;
    int peak_fill;

    function int nearest_match(logic [TW-1:0] key);
      for (int d = 1; d <= fill; d++) begin
        if (tags[fill - d] == key) return d;
      end
      return 0;
    endfunction

    function void note_op(func_t f, logic [HW-1:0] h, logic [TW-1:0] k);
      stack_result_t r;
      r = '0;
      ops++;
      case (f)
        FUNC_PUSH: begin
          if (fill >= STACK_DEPTH) begin
            r.fault = 1'b1;
            full_faults++;
          end else begin
            handles[fill] = h;
            tags[fill] = k;
            fill++;
            pushes++;
          end
        end
        FUNC_POP, FUNC_PEEK: begin
          if (fill == 0) begin
            r.fault = 1'b1;
            empty_faults++;
          end else begin
            r.handle = handles[fill - 1];
            if (f == FUNC_POP) fill--;
          end
        end
        default: begin
          r.position = CW'(nearest_match(k));
          if (r.position != 0) finds_hit++;
        end
      endcase
      r.count = CW'(fill);
      r.empty = (fill == 0);
      if (fill > peak_fill) peak_fill = fill;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] result %0d: %s", $time, checked, what);
    endtask

    task check_result(stack_result_t got);
      stack_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no operation outstanding");
      end else begin
        want = expected_results.pop_front();
        if (got.handle !== want.handle)
          report_mismatch($sformatf("handle got %0h want %0h", got.handle, want.handle));
        if (got.position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d", got.position, want.position));
        if (got.count !== want.count)
          report_mismatch($sformatf("entry count got %0d want %0d", got.count, want.count));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("empty flag got %0b want %0b", got.empty, want.empty));
        if (got.fault !== want.fault)
          report_mismatch($sformatf("fault got %0b want %0b", got.fault, want.fault));
      end
      checked++;
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    in_func = FUNC_FIND;
  logic [HW-1:0] in_node_handle = '0;
  logic [TW-1:0] in_tag_key = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [HW-1:0] out_handle;
  logic [CW-1:0] out_position;
  logic [CW-1:0] out_entry_count;
  logic          out_is_empty;
  logic          out_fault;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  stack_mirror mirror = new();

  searchable_element_stack_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_node_handle (in_node_handle),
    .in_tag_key     (in_tag_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_handle     (out_handle),
    .out_position   (out_position),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty),
    .out_fault      (out_fault)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      mirror.check_result({out_handle, out_position, out_entry_count, out_is_empty, out_fault});
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, mirror.expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_op(func_t f, logic [HW-1:0] h, logic [TW-1:0] k);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_node_handle <= h;
    in_tag_key <= k;
    do @(posedge clk); while (!in_ready);
    mirror.note_op(f, h, k);
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.expected_results.size() != 0);
  endtask

  function automatic logic [TW-1:0] rand_tag();
    if ($urandom_range(0, 1) == 0) return TW'($urandom_range(0, 7));
    return TW'($urandom_range(0, (1 << TW) - 1));
  endfunction

  function automatic logic [HW-1:0] rand_handle();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      default: return HW'($urandom_range(0, (1 << HW) - 1));
    endcase
  endfunction

  function automatic logic [TW-1:0] search_key();
    if (mirror.fill > 0 && $urandom_range(0, 1) == 0)
      return mirror.tags[$urandom_range(0, mirror.fill - 1)];
    return rand_tag();
  endfunction

  task automatic random_op(int push_pct);
    int r;
    func_t f;
    r = $urandom_range(0, 99);
    if (r < push_pct) f = FUNC_PUSH;
    else if (r < push_pct + 20) f = FUNC_FIND;
    else if (r < push_pct + 30) f = FUNC_PEEK;
    else f = FUNC_POP;
    send_op(f, rand_handle(), (f == FUNC_FIND) ? search_key() : rand_tag());
  endtask

  task automatic fill_to_top();
    while (mirror.fill < STACK_DEPTH) begin
      if ($urandom_range(0, 9) == 0) send_op(FUNC_FIND, rand_handle(), search_key());
      else send_op(FUNC_PUSH, rand_handle(), rand_tag());
    end
    repeat ($urandom_range(1, 3)) send_op(FUNC_PUSH, rand_handle(), rand_tag());
    send_op(FUNC_FIND, rand_handle(), search_key());
    send_op(FUNC_PEEK, rand_handle(), rand_tag());
  endtask

  task automatic drain_to_bottom();
    while (mirror.fill > 0) begin
      if ($urandom_range(0, 4) == 0) send_op(FUNC_FIND, rand_handle(), search_key());
      else send_op(FUNC_POP, rand_handle(), rand_tag());
    end
    send_op(FUNC_POP, rand_handle(), rand_tag());
    send_op(FUNC_PEEK, rand_handle(), rand_tag());
    send_op(FUNC_FIND, rand_handle(), rand_tag());
  endtask

  task automatic run_phase(int idle, int stall);
    int start;
    int push_pct;
    idle_pct = idle;
    stall_pct = stall;
    start = mirror.ops;
    fill_to_top();
    drain_to_bottom();
    while (mirror.ops - start < ITEMS_PER_PHASE) begin
      case ($urandom_range(0, 9))
        0: fill_to_top();
        1: drain_to_bottom();
        default: begin
          case ($urandom_range(0, 2))
            0: push_pct = 60;
            1: push_pct = 25;
            default: push_pct = 40;
          endcase
          repeat ($urandom_range(20, 40)) random_op(push_pct);
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_op(FUNC_POP, 16'h1111, 8'h00);
    send_op(FUNC_PEEK, 16'h2222, 8'h00);
    send_op(FUNC_FIND, 16'h0000, 8'hFF);
    send_op(FUNC_PUSH, 16'h0000, 8'h00);
    send_op(FUNC_PUSH, 16'hFFFF, 8'hFF);
    send_op(FUNC_PUSH, 16'h1234, 8'h55);
    send_op(FUNC_PUSH, 16'hABCD, 8'h55);
    send_op(FUNC_FIND, 16'h0000, 8'h55);
    send_op(FUNC_FIND, 16'h0000, 8'h00);
    send_op(FUNC_FIND, 16'h0000, 8'hFF);
    send_op(FUNC_FIND, 16'h0000, 8'hAA);
    send_op(FUNC_PEEK, 16'h0000, 8'h00);
    send_op(FUNC_POP, 16'h0000, 8'h00);
    send_op(FUNC_FIND, 16'h0000, 8'h55);
    send_op(FUNC_POP, 16'h0000, 8'h00);
    send_op(FUNC_POP, 16'h0000, 8'h00);
    send_op(FUNC_PEEK, 16'h0000, 8'h00);
    send_op(FUNC_POP, 16'h0000, 8'h00);
    send_op(FUNC_POP, 16'h0000, 8'h00);
    send_op(FUNC_FIND, 16'h0000, 8'h00);
    drain_pause();

    run_phase(0, 0);
    run_phase(74, 0);
    drain_pause();
    run_phase(0, 74);
    run_phase(34, 34);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (mirror.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d stack operations across four handshake phases:", mirror.ops);
    $display("  %0d pushes stored, %0d finds hit, peak depth %0d.",
             mirror.pushes, mirror.finds_hit, mirror.peak_fill);
    $display("Faults exercised: %0d pushes on a full stack, %0d pops or peeks on an empty one;",
             mirror.full_faults, mirror.empty_faults);
    $display("  %0d mismatches.", mirror.mismatches);
    if (mirror.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
sv/ses_pkg.sv
sv/ses_cell.sv
sv/ses_first_match.sv
sv/searchable_element_stack_unit.sv
bench/testbench.sv
